### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold whenever the antecedent holds, same cycle.
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### design/tchb_pkg.sv
// Shared types, constants and helpers of the TCP header and checksum builder.
package tchb_pkg;

  // Payload limit and derived widths
  localparam int MAX_PAYLOAD = 2048;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  // Segment descriptor queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Header constants
  localparam logic [15:0] HEADER_BYTES   = 16'd20;
  localparam logic [15:0] DEFAULT_WINDOW = 16'd5840;
  localparam logic [7:0]  OFFSET_BYTE    = 8'h50;
  localparam logic [15:0] PROTO_TCP      = 16'd6;
  localparam logic [2:0]  LAST_POS       = 3'd4;

  // Register port
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_SRC_ADDR    = 3'd0;
  localparam logic [2:0] REG_DST_ADDR    = 3'd1;
  localparam logic [2:0] REG_LOCAL_PORT  = 3'd2;
  localparam logic [2:0] REG_REMOTE_PORT = 3'd3;
  localparam logic [2:0] REG_WINDOW      = 3'd4;

  // One finished segment, handed from front to back
  typedef struct packed {
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [7:0]       flags;
    logic [15:0]      pay_sum;
    logic [7:0]       held;
    logic             odd;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } desc_t;

  // Configuration register contents
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [15:0] window;
  } cfg_t;

  // End-around carry fold of a sum of up to eight 16-bit terms
  function automatic logic [15:0] fold19(input logic [18:0] t);
    logic [16:0] s1;
    s1 = 17'(t[15:0]) + 17'(t[18:16]);
    return s1[15:0] + 16'(s1[16]);
  endfunction

endpackage

### design/tchb_front.sv
// Front end: accepts payload bytes, keeps the running payload sum, emits segment descriptors.
module tchb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_seq,
  input  logic [31:0]         in_ack,
  input  logic [7:0]          in_flags,
  input  logic [7:0]          in_byte,
  input  logic                in_present,
  input  logic                in_last,
  input  logic                q_full,
  output logic                push,
  output tchb_pkg::desc_t     push_desc
);

  logic [15:0]                sum, sum_next;
  logic [7:0]                 held, held_next;
  logic                       odd, odd_next;
  logic [tchb_pkg::CNT_W-1:0] count, count_next;
  logic                       ovf, ovf_next;
  logic                       accept, take;

  assign in_ready = ~q_full;

  // Fold a byte pair into the sum, hold a lone high byte, count and flag drops
  always_comb begin
    accept     = in_valid & in_ready;
    take       = accept & in_present & (count < tchb_pkg::CNT_W'(tchb_pkg::MAX_PAYLOAD));
    sum_next   = sum;
    held_next  = held;
    odd_next   = odd;
    count_next = count;
    ovf_next   = ovf;
    if (take) begin
      count_next = count + 1'b1;
      if (odd) begin
        sum_next  = tchb_pkg::fold19(19'(sum) + 19'({held, in_byte}));
        held_next = 8'h00;
        odd_next  = 1'b0;
      end else begin
        held_next = in_byte;
        odd_next  = 1'b1;
      end
    end
    if (accept & in_present & ~take) begin
      ovf_next = 1'b1;
    end
    push              = accept & in_last;
    push_desc.seq     = in_seq;
    push_desc.ack     = in_ack;
    push_desc.flags   = in_flags;
    push_desc.pay_sum = sum_next;
    push_desc.held    = held_next;
    push_desc.odd     = odd_next;
    push_desc.count   = count_next;
    push_desc.ovf     = ovf_next;
  end

  // Hold segment state; clear it once the segment is handed off
  always_ff @(posedge clk) begin
    if (rst || push) begin
      sum   <= '0;
      held  <= '0;
      odd   <= 1'b0;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      sum   <= sum_next;
      held  <= held_next;
      odd   <= odd_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

endmodule

### design/tchb_queue.sv
// Short descriptor queue between the front and back ends.
module tchb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tchb_pkg::desc_t push_desc,
  input  logic            pop,
  output tchb_pkg::desc_t head,
  output logic            empty,
  output logic            full
);

  tchb_pkg::desc_t             mem [tchb_pkg::QUEUE_DEPTH];
  logic [tchb_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [tchb_pkg::QCNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == tchb_pkg::QCNT_W'(tchb_pkg::QUEUE_DEPTH));
  assign head  = mem[rd_ptr];

  // Store the pushed descriptor
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tchb_pkg::QPTR_W'(tchb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tchb_pkg::QPTR_W'(tchb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### design/tchb_back.sv
// Back end: finishes the checksum and sends the five header words.
module tchb_back (
  input  logic            clk,
  input  logic            rst,
  input  tchb_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  tchb_pkg::desc_t q_head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_word,
  output logic [2:0]      out_pos,
  output logic            out_last,
  output logic            out_ovf
);

  typedef enum logic [2:0] {
    STEP_SRC,
    STEP_DST_LEN,
    STEP_PORTS_SEQ,
    STEP_ACK_WIN,
    STEP_DONE
  } step_t;

  tchb_pkg::desc_t work;
  logic            busy;
  step_t           step, step_next;
  logic [2:0]      pos;
  logic [15:0]     acc;
  logic [15:0]     t0, t1, t2, t3;
  logic [15:0]     len;
  logic            out_fire, free;

  assign len = tchb_pkg::HEADER_BYTES + 16'(work.count);

  // Pick four terms of the checksum for this step
  always_comb begin
    t0 = '0;
    t1 = '0;
    t2 = '0;
    t3 = '0;
    step_next = step;
    case (step)
      STEP_SRC: begin
        t0 = work.pay_sum;
        t1 = work.odd ? {work.held, 8'h00} : 16'h0000;
        t2 = cfg.src_addr[31:16];
        t3 = cfg.src_addr[15:0];
        step_next = STEP_DST_LEN;
      end
      STEP_DST_LEN: begin
        t0 = cfg.dst_addr[31:16];
        t1 = cfg.dst_addr[15:0];
        t2 = tchb_pkg::PROTO_TCP;
        t3 = len;
        step_next = STEP_PORTS_SEQ;
      end
      STEP_PORTS_SEQ: begin
        t0 = cfg.local_port;
        t1 = cfg.remote_port;
        t2 = work.seq[31:16];
        t3 = work.seq[15:0];
        step_next = STEP_ACK_WIN;
      end
      STEP_ACK_WIN: begin
        t0 = work.ack[31:16];
        t1 = work.ack[15:0];
        t2 = {tchb_pkg::OFFSET_BYTE, work.flags};
        t3 = cfg.window;
        step_next = STEP_DONE;
      end
      default: begin
        step_next = STEP_DONE;
      end
    endcase
  end

  // Select the header word at the current position
  always_comb begin
    case (pos)
      3'd0:    out_word = {cfg.local_port, cfg.remote_port};
      3'd1:    out_word = work.seq;
      3'd2:    out_word = work.ack;
      3'd3:    out_word = {tchb_pkg::OFFSET_BYTE, work.flags, cfg.window};
      default: out_word = {~acc, 16'h0000};
    endcase
  end

  assign out_valid = busy & ((pos != tchb_pkg::LAST_POS) | (step == STEP_DONE));
  assign out_pos   = pos;
  assign out_last  = (pos == tchb_pkg::LAST_POS);
  assign out_ovf   = work.ovf;
  assign out_fire  = out_valid & out_ready;
  assign free      = ~busy | (out_fire & out_last);
  assign pop       = free & ~q_empty;

  // Load a descriptor, run the sum steps, step through the words
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_DONE;
      pos  <= '0;
      acc  <= '0;
    end else if (pop) begin
      work <= q_head;
      busy <= 1'b1;
      step <= STEP_SRC;
      pos  <= '0;
      acc  <= '0;
    end else begin
      if (step != STEP_DONE) begin
        acc  <= tchb_pkg::fold19(19'(acc) + 19'(t0) + 19'(t1) + 19'(t2) + 19'(t3));
        step <= step_next;
      end
      if (out_fire) begin
        if (out_last) begin
          busy <= 1'b0;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

### design/tcp_header_checksum_builder.sv
// Top level of the TCP header and checksum builder: register port, front, queue, back.
//
//  Channel  Dir  Handshake               Payload
//  s_*      in   s_tvalid / s_tready     tdata: seq, ack, flags, byte; tuser: present; tlast
//  m_*      out  m_tvalid / m_tready     tdata: header word; tuser: position, overflow; tlast
//  APB      in   psel & penable & pwrite source/dest address, ports, window
//
// One payload byte is taken per cycle while the two-entry descriptor queue has room.
// Each end-of-segment word yields five header words from the back end, one per cycle while m_tready
// is high; word 0 follows once the descriptor is written to the queue and loaded into the back end.
// s_tready drops only while the queue is full; m_tready stalls only the back end.
// Synchronous reset clears segment state and sets the window register to 5840.
`include "assert_macros.svh"

module tcp_header_checksum_builder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [79:0]                 s_tdata,  // sequence_number, ack_number, control_flags, payload_byte
  input  logic                        s_tuser,  // byte_present
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,  // header_word
  output logic [3:0]                  m_tuser,  // word_position, payload_overflow
  output logic                        m_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tchb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  tchb_pkg::cfg_t  cfg;
  tchb_pkg::desc_t push_desc, head;
  logic            push, pop, q_empty, q_full;
  logic [2:0]      reg_idx;
  logic [2:0]      out_pos;
  logic            out_ovf;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_addr    <= '0;
      cfg.dst_addr    <= '0;
      cfg.local_port  <= '0;
      cfg.remote_port <= '0;
      cfg.window      <= tchb_pkg::DEFAULT_WINDOW;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        tchb_pkg::REG_SRC_ADDR:    cfg.src_addr    <= pwdata;
        tchb_pkg::REG_DST_ADDR:    cfg.dst_addr    <= pwdata;
        tchb_pkg::REG_LOCAL_PORT:  cfg.local_port  <= pwdata[15:0];
        tchb_pkg::REG_REMOTE_PORT: cfg.remote_port <= pwdata[15:0];
        tchb_pkg::REG_WINDOW:      cfg.window      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      tchb_pkg::REG_SRC_ADDR:    prdata = cfg.src_addr;
      tchb_pkg::REG_DST_ADDR:    prdata = cfg.dst_addr;
      tchb_pkg::REG_LOCAL_PORT:  prdata = {16'h0000, cfg.local_port};
      tchb_pkg::REG_REMOTE_PORT: prdata = {16'h0000, cfg.remote_port};
      tchb_pkg::REG_WINDOW:      prdata = {16'h0000, cfg.window};
      default:                   prdata = '0;
    endcase
  end

  tchb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_seq     (s_tdata[31:0]),
    .in_ack     (s_tdata[63:32]),
    .in_flags   (s_tdata[71:64]),
    .in_byte    (s_tdata[79:72]),
    .in_present (s_tuser),
    .in_last    (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  tchb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tchb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata),
    .out_pos   (out_pos),
    .out_last  (m_tlast),
    .out_ovf   (out_ovf)
  );

  assign m_tuser = {out_ovf, out_pos};

  // Checks on header word sequencing
  `ASSERT_IMPLIES(a_last_at_tail, m_tvalid, m_tlast == (m_tuser[2:0] == tchb_pkg::LAST_POS), "final word flag off the last position")
  `ASSERT_NEXT(a_pos_advance, m_tvalid && m_tready && !m_tlast, m_tuser[2:0] == $past(m_tuser[2:0]) + 3'd1, "word position skipped")
  `ASSERT_NEXT(a_ovf_steady, m_tvalid && m_tready && !m_tlast, m_tuser[3] == $past(m_tuser[3]), "overflow flag changed within a header")

endmodule

### bench/tb_tcp_header_checksum_builder.sv
// Self-checking testbench for the TCP header and checksum builder.
`timescale 1ns / 1ps

module tb_tcp_header_checksum_builder;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  localparam int REPORT_MAX     = 10;
  localparam int PHASE_ITEMS    = 90;
  localparam int DIR_ROWS       = 16;

  // Index past the register map; writes there must change nothing
  localparam logic [2:0] REG_UNMAPPED = 3'd5;

  // Header word 3 after reset with an empty payload
  localparam logic [31:0] RESET_W3 = 32'h5000_16d0;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [7:0]  data;
    logic        present;
    logic        last;
  } seg_item_t;

  typedef struct packed {
    seg_item_t   item;
    logic        typed;
    logic [31:0] w3;
    logic [31:0] w4;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
    logic        ovf;
  } hdr_word_t;

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [79:0]                 s_tdata  = '0;  // sequence_number, ack_number, control_flags, payload_byte
  logic                        s_tuser  = 1'b0;  // byte_present
  logic                        s_tlast  = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [31:0]                 m_tdata;  // header_word
  logic [3:0]                  m_tuser;  // word_position, payload_overflow
  logic                        m_tlast;
  logic                        psel     = 1'b0;
  logic                        penable  = 1'b0;
  logic                        pwrite   = 1'b0;
  logic [tchb_pkg::ADDR_W-1:0] paddr    = '0;
  logic [31:0]                 pwdata   = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  tcp_header_checksum_builder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // Mirror of the register file
  logic [31:0] cfg_src    = '0;
  logic [31:0] cfg_dst    = '0;
  logic [15:0] cfg_lport  = '0;
  logic [15:0] cfg_rport  = '0;
  logic [15:0] cfg_window = tchb_pkg::DEFAULT_WINDOW;

  // Mirror of the per-segment accumulator
  logic [15:0] pay_sum   = '0;
  int unsigned pay_count = 0;
  logic [7:0]  held_byte = '0;
  bit          odd_byte  = 1'b0;
  bit          dropped   = 1'b0;

  hdr_word_t   hdr_expect_q[$];
  int          mismatches  = 0;
  int          items_sent  = 0;
  int          idle_cycles = 0;
  dir_row_t    dir_table [DIR_ROWS];

  function automatic logic [15:0] ones_fold(input logic [31:0] s);
    logic [31:0] t;
    t = 32'(s[31:16]) + 32'(s[15:0]);
    t = 32'(t[31:16]) + 32'(t[15:0]);
    return t[15:0];
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic seg_item_t random_item();
    seg_item_t it;
    it.seq     = rand32();
    it.ack     = rand32();
    it.flags   = 8'(rand32());
    it.data    = 8'(rand32());
    it.present = 1'b0;
    it.last    = 1'b0;
    return it;
  endfunction

  function automatic int seg_length();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r <= 7) return $urandom_range(24, 1);
    return $urandom_range(80, 25);
  endfunction

  task automatic note_failure(input string msg);
    if (mismatches < REPORT_MAX) $display("%s", msg);
    mismatches++;
  endtask

  // Fold one accepted word into the accumulator; on the end word queue the header
  task automatic absorb_item(input seg_item_t it, input logic typed,
                             input logic [31:0] w3_typed, input logic [31:0] w4_typed);
    logic [31:0] s;
    logic [15:0] seg_len;
    logic [15:0] folded;
    logic [31:0] words [5];
    hdr_word_t   hw;
    int          k;
    if (it.present) begin
      if (pay_count < tchb_pkg::MAX_PAYLOAD) begin
        if (odd_byte) begin
          pay_sum   = ones_fold(32'(pay_sum) + 32'({held_byte, it.data}));
          held_byte = '0;
          odd_byte  = 1'b0;
        end else begin
          held_byte = it.data;
          odd_byte  = 1'b1;
        end
        pay_count++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (it.last) begin
      // Pseudo-header, then header with zero checksum, folding as the words go in
      seg_len = tchb_pkg::HEADER_BYTES + 16'(pay_count);
      s = 32'(pay_sum);
      if (odd_byte) s = s + 32'({held_byte, 8'd0});
      s = s + 32'(cfg_src[31:16]) + 32'(cfg_src[15:0]);
      s = s + 32'(cfg_dst[31:16]) + 32'(cfg_dst[15:0]);
      s = s + 32'(tchb_pkg::PROTO_TCP) + 32'(seg_len);
      s = 32'(ones_fold(s));
      s = s + 32'(cfg_lport) + 32'(cfg_rport);
      s = s + 32'(it.seq[31:16]) + 32'(it.seq[15:0]);
      s = 32'(ones_fold(s));
      s = s + 32'(it.ack[31:16]) + 32'(it.ack[15:0]);
      s = s + 32'({tchb_pkg::OFFSET_BYTE, it.flags}) + 32'(cfg_window);
      folded = ones_fold(s);

      words[0] = {cfg_lport, cfg_rport};
      words[1] = it.seq;
      words[2] = it.ack;
      words[3] = {tchb_pkg::OFFSET_BYTE, it.flags, cfg_window};
      words[4] = {~folded, 16'd0};
      if (typed) begin
        words[3] = w3_typed;
        words[4] = w4_typed;
      end
      for (k = 0; k < 5; k++) begin
        hw.word = words[k];
        hw.pos  = 3'(k);
        hw.last = (3'(k) == tchb_pkg::LAST_POS);
        hw.ovf  = dropped;
        hdr_expect_q.push_back(hw);
      end
      pay_sum   = '0;
      pay_count = 0;
      held_byte = '0;
      odd_byte  = 1'b0;
      dropped   = 1'b0;
    end
  endtask

  // Drive one word after a random gap and hold it until accepted
  task automatic send_item(input seg_item_t it, input logic typed,
                           input logic [31:0] w3, input logic [31:0] w4, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(15);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {it.data, it.flags, it.ack, it.seq};
    s_tuser  <= it.present;
    s_tlast  <= it.last;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    absorb_item(it, typed, w3, w4);
  endtask

  // One segment of len payload bytes with stray absent-byte words mixed in
  task automatic send_segment(input int len);
    bit        burst;
    bit        byte_on_last;
    int        k;
    seg_item_t it;
    burst        = ($urandom_range(3) == 0);
    byte_on_last = (len > 0) && ($urandom_range(1) == 1);
    for (k = 0; k < len - int'(byte_on_last); k++) begin
      if ($urandom_range(7) == 0) send_item(random_item(), 1'b0, '0, '0, burst);
      it         = random_item();
      it.present = 1'b1;
      send_item(it, 1'b0, '0, '0, burst);
      items_sent++;
    end
    it         = random_item();
    it.present = byte_on_last;
    it.last    = 1'b1;
    send_item(it, 1'b0, '0, '0, burst);
    items_sent++;
  endtask

  task automatic run_phase(input int target, input int big_len);
    int start;
    start = items_sent;
    while (items_sent - start < target) send_segment(seg_length());
    if (big_len > 0) send_segment(big_len);
  endtask

  // Drop valid and wait until every header word is out and the block is quiet
  task automatic settle_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (hdr_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!(psel && penable && pready));
    case (idx)
      tchb_pkg::REG_SRC_ADDR:    cfg_src    = val;
      tchb_pkg::REG_DST_ADDR:    cfg_dst    = val;
      tchb_pkg::REG_LOCAL_PORT:  cfg_lport  = val[15:0];
      tchb_pkg::REG_REMOTE_PORT: cfg_rport  = val[15:0];
      tchb_pkg::REG_WINDOW:      cfg_window = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read a register back and compare the bits it holds
  task automatic check_reg(input logic [2:0] idx, input logic [31:0] want, input bit wide);
    logic [31:0] mask;
    mask = wide ? 32'hffff_ffff : 32'h0000_ffff;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!(psel && penable && pready));
    if ((prdata & mask) !== (want & mask))
      note_failure($sformatf("register %0d read: expected %h, got %h", idx, want & mask,
                             prdata & mask));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(input logic [31:0] src, input logic [31:0] dst,
                              input logic [15:0] lport, input logic [15:0] rport,
                              input logic [15:0] win, input bit hit_unmapped);
    write_reg(tchb_pkg::REG_SRC_ADDR, src);
    write_reg(tchb_pkg::REG_DST_ADDR, dst);
    write_reg(tchb_pkg::REG_LOCAL_PORT, 32'(lport));
    write_reg(tchb_pkg::REG_REMOTE_PORT, 32'(rport));
    write_reg(tchb_pkg::REG_WINDOW, 32'(win));
    if (hit_unmapped) write_reg(REG_UNMAPPED, $urandom);
    check_reg(tchb_pkg::REG_SRC_ADDR, cfg_src, 1'b1);
    check_reg(tchb_pkg::REG_DST_ADDR, cfg_dst, 1'b1);
    check_reg(tchb_pkg::REG_LOCAL_PORT, 32'(cfg_lport), 1'b0);
    check_reg(tchb_pkg::REG_REMOTE_PORT, 32'(cfg_rport), 1'b0);
    check_reg(tchb_pkg::REG_WINDOW, 32'(cfg_window), 1'b0);
  endtask

  // Header sink: random stalls per word, with bursts of full-rate acceptance
  initial begin : header_sink
    hdr_word_t exp_w;
    int        stall;
    int        run_left;
    bit        run_fast;
    run_left = 0;
    run_fast = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (run_left == 0) begin
        run_fast = ($urandom_range(3) == 0);
        run_left = 16;
      end
      run_left--;
      stall = run_fast ? 0 : $urandom_range(15);
      if (stall > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      if (hdr_expect_q.size() == 0) begin
        note_failure($sformatf("unexpected header word %h pos %0d", m_tdata, m_tuser[2:0]));
      end else begin
        exp_w = hdr_expect_q.pop_front();
        if (m_tdata !== exp_w.word || m_tuser[2:0] !== exp_w.pos ||
            m_tlast !== exp_w.last || m_tuser[3] !== exp_w.ovf)
          note_failure($sformatf(
            {"header word mismatch: expected %h pos %0d last %0b ovf %0b, ",
             "got %h pos %0d last %0b ovf %0b"},
            exp_w.word, exp_w.pos, exp_w.last, exp_w.ovf,
            m_tdata, m_tuser[2:0], m_tlast, m_tuser[3]));
      end
    end
  end

  // Abort when nothing moves on any port for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    // Columns: seq, ack, flags, byte, present, last | typed, word 3, word 4
    dir_table = '{
      // empty segment with reset registers
      '{'{32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 1'b0, 1'b1}, 1'b1, RESET_W3, 32'h9915_0000},
      // folded sum of all ones gives a zero checksum
      '{'{32'h0000_9915, 32'h0000_0000, 8'h00, 8'h00, 1'b0, 1'b1}, 1'b1, RESET_W3, 32'h0000_0000},
      // absent byte, not the end: ignored
      '{'{32'hffff_ffff, 32'hffff_ffff, 8'hff, 8'hff, 1'b0, 1'b0}, 1'b0, '0, '0},
      // lone byte carried on the end word
      '{'{32'hffff_ffff, 32'hffff_ffff, 8'hff, 8'hff, 1'b1, 1'b1}, 1'b0, '0, '0},
      // three bytes with an absent word in between, odd count at the end
      '{'{32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 1'b1, 1'b0}, 1'b0, '0, '0},
      '{'{32'h0000_0000, 32'h0000_0000, 8'h00, 8'hff, 1'b1, 1'b0}, 1'b0, '0, '0},
      '{'{32'h5555_aaaa, 32'haaaa_5555, 8'h5a, 8'h5a, 1'b0, 1'b0}, 1'b0, '0, '0},
      '{'{32'h0000_0000, 32'hffff_ffff, 8'h00, 8'h80, 1'b1, 1'b1}, 1'b0, '0, '0},
      // odd byte left pending, end word without a byte
      '{'{32'h0000_0000, 32'h0000_0000, 8'h00, 8'h12, 1'b1, 1'b0}, 1'b0, '0, '0},
      '{'{32'h0000_0000, 32'h0000_0000, 8'h00, 8'h34, 1'b1, 1'b0}, 1'b0, '0, '0},
      '{'{32'h0000_0000, 32'h0000_0000, 8'h00, 8'h56, 1'b1, 1'b0}, 1'b0, '0, '0},
      '{'{32'h1234_5678, 32'h9abc_def0, 8'h12, 8'ha5, 1'b0, 1'b1}, 1'b0, '0, '0},
      // all-ones payload forces end-around carries
      '{'{32'h0000_0000, 32'h0000_0000, 8'h00, 8'hff, 1'b1, 1'b0}, 1'b0, '0, '0},
      '{'{32'h0000_0000, 32'h0000_0000, 8'h00, 8'hff, 1'b1, 1'b0}, 1'b0, '0, '0},
      '{'{32'h0000_0000, 32'h0000_0000, 8'h00, 8'hff, 1'b1, 1'b0}, 1'b0, '0, '0},
      '{'{32'hffff_0000, 32'h0000_ffff, 8'h3f, 8'hff, 1'b1, 1'b1}, 1'b0, '0, '0}
    };

    // Hold reset, then release it on a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIR_ROWS; r++)
      send_item(dir_table[r].item, dir_table[r].typed, dir_table[r].w3, dir_table[r].w4,
                $urandom_range(1) == 1);
    run_phase(PHASE_ITEMS, 0);
    settle_results();

    // All-ones registers
    apply_config(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    run_phase(PHASE_ITEMS, 0);
    settle_results();

    // All-zero registers and one segment exactly at the payload limit
    apply_config(32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0);
    run_phase(PHASE_ITEMS, tchb_pkg::MAX_PAYLOAD);
    settle_results();

    // Random settings, one of them with a write past the register map
    apply_config(rand32(), rand32(), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    run_phase(PHASE_ITEMS, 0);
    settle_results();

    // Random settings and one segment past the limit
    apply_config(rand32(), rand32(), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    run_phase(PHASE_ITEMS, tchb_pkg::MAX_PAYLOAD + int'($urandom_range(8, 1)));
    settle_results();

    apply_config(rand32(), rand32(), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    run_phase(PHASE_ITEMS, 0);
    settle_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && hdr_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
